// ----- src/bffa_pkg.sv -----
package bffa_pkg;

   // field widths of the command and result transfers
   localparam int unsigned UNIT_W   = 12;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FIRST_W  = 12;
   localparam int unsigned TOTAL_W  = 13;
   localparam int unsigned CSR_W    = 13;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd2;

   // register indexes
   localparam logic CSR_FIRST_INDEX = 1'b0;
   localparam logic CSR_TOTAL_COUNT = 1'b1;

   // register reset values
   localparam logic [FIRST_W-1:0] FIRST_INDEX_RST = 12'd1;
   localparam logic [TOTAL_W-1:0] TOTAL_COUNT_RST = 13'd4096;

   typedef struct packed {
      logic              command;
      logic [UNIT_W-1:0] unit_index;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0]   granted_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ----- src/bitmap_first_free_allocator.sv -----
// channel   ports                              direction  transfer
// command   start, busy, req_data              in         start high while busy low
// result    rsp_done, rsp_data                 out        one cycle, rsp_done high
// config    csr_we, csr_index, csr_wdata       in         csr_we high
//
// After reset a clearing pass writes every bitmap word to zero, one word per cycle, with
// busy high. An allocate reads one bitmap word per cycle through a single registered
// read port and tests it in one lowest-zero search unit. A free is a read-modify-write
// of one word; a rejected command is answered without touching the bitmap.
// The result appears the cycle after the command finishes; the receiver cannot stall it.
module bitmap_first_free_allocator #(
   parameter int unsigned BITMAP_BITS    = 4096,
   parameter int unsigned SCAN_WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bffa_pkg::req_type  req_data,
   output logic               rsp_done,
   output bffa_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [bffa_pkg::CSR_W-1:0] csr_wdata
);

   import bffa_pkg::*;

   localparam int unsigned WORDS = (BITMAP_BITS + SCAN_WORD_BITS - 1) / SCAN_WORD_BITS;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned BW    = $clog2(SCAN_WORD_BITS);
   localparam int unsigned SW    = SCAN_WORD_BITS;
   localparam int unsigned LW    = $clog2(BITMAP_BITS) + 1;
   localparam int unsigned CW    = (LW > TOTAL_W) ? LW : TOTAL_W;

   // sequencer codes
   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_FREE_RD = 3'd3;
   localparam logic [2:0] ST_FREE_WR = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in;
   logic [AW-1:0]      chk_addr_ff, chk_addr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [AW-1:0]      first_word_ff, first_word_in;
   logic [BW-1:0]      first_bit_ff, first_bit_in;
   logic [AW-1:0]      last_word_ff, last_word_in;
   logic [BW-1:0]      last_bit_ff, last_bit_in;
   logic [BW-1:0]      free_bit_ff, free_bit_in;
   logic [FIRST_W-1:0] first_index_ff, first_index_in;
   logic [TOTAL_W-1:0] total_count_ff, total_count_in;
   logic               rsp_done_ff, rsp_done_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // bitmap store
   logic [SW-1:0] bitmap_mem [WORDS];
   logic [SW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [SW-1:0] mem_wdata;

   // scan helpers
   logic          accept;
   logic [CW-1:0] first_ext, total_ext, limit, limit_m1, unit_ext;
   logic [SW-1:0] lo_mask, hi_mask, masked_word, free_vec;
   logic          any_free;
   logic [BW-1:0] found_bit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_done  = rsp_done_ff;
   assign rsp_data  = rsp_data_ff;

   // scan bounds from the registers
   assign first_ext = CW'(first_index_ff);
   assign total_ext = CW'(total_count_ff);
   assign limit     = (total_ext > CW'(BITMAP_BITS)) ? CW'(BITMAP_BITS) : total_ext;
   assign limit_m1  = limit - CW'(1);
   assign unit_ext  = CW'(req_data.unit_index);

   // lowest-zero search on the word under test
   always_comb begin
      lo_mask = '0;
      hi_mask = '0;
      if (chk_addr_ff == first_word_ff) begin
         lo_mask = (SW'(1) << first_bit_ff) - SW'(1);
      end
      if (chk_addr_ff == last_word_ff) begin
         hi_mask = ~((SW'(2) << last_bit_ff) - SW'(1));
      end
      masked_word = rd_data_ff | lo_mask | hi_mask;
      free_vec    = ~masked_word;
      any_free    = |free_vec;
      found_bit   = '0;
      for (int i = SW - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found_bit = BW'(i);
         end
      end
   end

   // configuration writes
   always_comb begin
      first_index_in = first_index_ff;
      total_count_in = total_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_INDEX: first_index_in = csr_wdata[FIRST_W-1:0];
            CSR_TOTAL_COUNT: total_count_in = csr_wdata[TOTAL_W-1:0];
            default:         first_index_in = first_index_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      chk_addr_in   = chk_addr_ff;
      chk_valid_in  = chk_valid_ff;
      first_word_in = first_word_ff;
      first_bit_in  = first_bit_ff;
      last_word_in  = last_word_ff;
      last_bit_in   = last_bit_ff;
      free_bit_in   = free_bit_ff;
      rsp_done_in   = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_addr_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            scan_addr_in = scan_addr_ff + AW'(1);
            if (scan_addr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_ALLOC) begin
                  if (first_ext >= limit) begin
                     rsp_done_in = 1'b1;
                     rsp_data_in = '{granted_index: '0, status: STATUS_FULL};
                  end else begin
                     first_word_in = AW'(first_ext >> BW);
                     first_bit_in  = first_ext[BW-1:0];
                     last_word_in  = AW'(limit_m1 >> BW);
                     last_bit_in   = limit_m1[BW-1:0];
                     scan_addr_in  = AW'(first_ext >> BW);
                     chk_valid_in  = 1'b0;
                     state_in      = ST_SCAN;
                  end
               end else begin
                  if (req_data.unit_index == '0 || unit_ext >= CW'(BITMAP_BITS)) begin
                     rsp_done_in = 1'b1;
                     rsp_data_in = '{granted_index: '0, status: STATUS_BAD_IDX};
                  end else begin
                     scan_addr_in = AW'(req_data.unit_index >> BW);
                     free_bit_in  = req_data.unit_index[BW-1:0];
                     state_in     = ST_FREE_RD;
                  end
               end
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous word is tested
            scan_addr_in = scan_addr_ff + AW'(1);
            chk_addr_in  = scan_addr_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (any_free) begin
                  mem_we      = 1'b1;
                  mem_waddr   = chk_addr_ff;
                  mem_wdata   = rd_data_ff | (SW'(1) << found_bit);
                  rsp_done_in = 1'b1;
                  rsp_data_in = '{granted_index: UNIT_W'({chk_addr_ff, found_bit}),
                                  status: STATUS_OK};
                  state_in    = ST_IDLE;
               end else if (chk_addr_ff == last_word_ff) begin
                  rsp_done_in = 1'b1;
                  rsp_data_in = '{granted_index: '0, status: STATUS_FULL};
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_FREE_RD: begin
            state_in = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            mem_we      = 1'b1;
            mem_wdata   = rd_data_ff & ~(SW'(1) << free_bit_ff);
            rsp_done_in = 1'b1;
            rsp_data_in = '{granted_index: '0, status: STATUS_OK};
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[scan_addr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         scan_addr_ff   <= '0;
         chk_valid_ff   <= 1'b0;
         rsp_done_ff    <= 1'b0;
         first_index_ff <= FIRST_INDEX_RST;
         total_count_ff <= TOTAL_COUNT_RST;
      end else begin
         state_ff       <= state_in;
         scan_addr_ff   <= scan_addr_in;
         chk_valid_ff   <= chk_valid_in;
         rsp_done_ff    <= rsp_done_in;
         first_index_ff <= first_index_in;
         total_count_ff <= total_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      first_word_ff <= first_word_in;
      first_bit_ff  <= first_bit_in;
      last_word_ff  <= last_word_in;
      last_bit_ff   <= last_bit_in;
      free_bit_ff   <= free_bit_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // an accepted command either keeps the block busy or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_done))
      else $error("accepted command neither started nor answered");

   // only a successful allocate carries a non-zero index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_data.status != STATUS_OK) |-> (rsp_data.granted_index == '0))
      else $error("failed command returned an index");

   // the scan never tests a word beyond the last one in range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_valid_ff) |-> (chk_addr_ff <= last_word_ff))
      else $error("scan ran past the limit word");

   // no result is produced during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_done)
      else $error("result during clearing pass");

endmodule

// ----- verif/bffa_alloc_checker.sv -----
`timescale 1ns / 1ps

module bffa_alloc_checker #(
   parameter int unsigned BITMAP_BITS = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  bffa_pkg::req_type          req_data,
   input  logic                       rsp_done,
   input  bffa_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [bffa_pkg::CSR_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         pending_results
);

   import bffa_pkg::*;

   // shadow copy of the usage bitmap and the scan window
   logic               unit_used [BITMAP_BITS];
   logic [FIRST_W-1:0] scan_first;
   logic [TOTAL_W-1:0] scan_total;

   // outcomes still owed by the block, oldest first
   rsp_type owed_outcomes[$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // first-fit allocate or free against the shadow bitmap
   function automatic rsp_type allocate_or_free(input req_type cmd);
      rsp_type     outcome;
      int unsigned scan_end;
      outcome.granted_index = '0;
      if (cmd.command == CMD_ALLOC) begin
         outcome.status = STATUS_FULL;
         // scan range saturates at the bitmap size
         scan_end = (scan_total > BITMAP_BITS) ? BITMAP_BITS : scan_total;
         for (int unsigned u = scan_first; u < scan_end; u++) begin
            if (!unit_used[u]) begin
               unit_used[u]          = 1'b1;
               outcome.granted_index = UNIT_W'(u);
               outcome.status        = STATUS_OK;
               break;
            end
         end
      end else if (cmd.unit_index == '0 || cmd.unit_index >= BITMAP_BITS) begin
         // unit zero and units past the bitmap are refused
         outcome.status = STATUS_BAD_IDX;
      end else begin
         // freeing is allowed past the count and on an already free unit
         unit_used[cmd.unit_index] = 1'b0;
         outcome.status            = STATUS_OK;
      end
      return outcome;
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (unit_used[u]) unit_used[u] = 1'b0;
         scan_first = FIRST_INDEX_RST;
         scan_total = TOTAL_COUNT_RST;
         owed_outcomes.delete();
      end else begin
         // result transfer against the oldest owed outcome
         if (rsp_done) begin
            if (owed_outcomes.size() == 0) begin
               report_mismatch($sformatf("result with nothing owed (index %0d, status %0d)",
                                         rsp_data.granted_index, rsp_data.status));
            end else begin
               want = owed_outcomes.pop_front();
               if (rsp_data.granted_index != want.granted_index)
                  report_mismatch($sformatf("granted_index %0d, expected %0d",
                                            rsp_data.granted_index, want.granted_index));
               if (rsp_data.status != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
            end
         end
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_FIRST_INDEX)
               scan_first = csr_wdata[FIRST_W-1:0];
            else
               scan_total = csr_wdata[TOTAL_W-1:0];
         end
         // command transfer
         if (start && !busy)
            owed_outcomes.push_back(allocate_or_free(req_data));
      end
      pending_results = owed_outcomes.size();
   end

endmodule

// ----- verif/bitmap_first_free_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_first_free_allocator_tb;
   import bffa_pkg::*;

   localparam int unsigned BITMAP_BITS    = 4096;
   localparam int unsigned COMMAND_TARGET = 1450;
   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int unsigned SETTLE_CYCLES  = 140;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_data  = '0;
   logic             csr_we    = 1'b0;
   logic             csr_index = CSR_FIRST_INDEX;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic             busy;
   logic             rsp_done;
   rsp_type          rsp_data;

   int          mismatch_count;
   int          pending_results;
   int unsigned cycle_count   = 0;
   int unsigned commands_sent = 0;
   int          burst_left    = 6;
   // range the frees aim at, so that they mostly hit allocated units
   int unsigned free_lo = 1;
   int unsigned free_hi = 65;

   bitmap_first_free_allocator #(
      .BITMAP_BITS   (BITMAP_BITS),
      .SCAN_WORD_BITS(32)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_done (rsp_done),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   bffa_alloc_checker #(
      .BITMAP_BITS(BITMAP_BITS)
   ) alloc_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_done       (rsp_done),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_first_free_allocator_tb: done, errors");
         $finish;
      end
   end

   // present one command and hold it until the block takes it
   task automatic send_command(input logic cmd, input logic [UNIT_W-1:0] unit);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{command: cmd, unit_index: unit};
      @(posedge clock);
      while (busy) @(posedge clock);
      commands_sent++;
      // bursts of random length, mostly with a gap after each
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // stop sending and wait until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0 || busy) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // reprogram the scan window while idle and aim the frees at it
   task automatic set_window(input logic [CSR_W-1:0] first_val,
                             input logic [CSR_W-1:0] total_val);
      int unsigned lo;
      int unsigned hi;
      drain_results();
      write_csr(CSR_FIRST_INDEX, first_val);
      write_csr(CSR_TOTAL_COUNT, total_val);
      lo = first_val & 13'h0FFF;
      hi = total_val;
      if (hi > BITMAP_BITS) hi = BITMAP_BITS;
      if (hi > lo + 64) hi = lo + 64;
      free_lo = lo;
      free_hi = hi;
   endtask

   initial begin
      int unsigned pick;
      int unsigned phase_len;
      int unsigned first_pick;
      int unsigned total_pick;
      logic [UNIT_W-1:0] unit;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset window first 1, count 4096
      send_command(CMD_ALLOC, 12'h000);
      send_command(CMD_ALLOC, 12'hFFF);
      send_command(CMD_ALLOC, 12'hAAA);
      send_command(CMD_FREE, 12'h000);          // unit zero refused
      send_command(CMD_FREE, 12'h002);
      send_command(CMD_FREE, 12'h002);          // already free
      send_command(CMD_ALLOC, 12'h555);
      send_command(CMD_FREE, 12'hFFF);          // top unit, never used
      send_command(CMD_FREE, 12'h555);
      // window starting at zero, full after one grant
      set_window(13'd0, 13'd3);
      send_command(CMD_ALLOC, 12'h000);
      send_command(CMD_ALLOC, 12'h000);
      send_command(CMD_FREE, 12'h003);          // past the count, still cleared
      send_command(CMD_FREE, 12'h800);
      // count past the bitmap, single top unit
      set_window(13'd4095, 13'h1FFF);
      send_command(CMD_ALLOC, 12'h123);
      send_command(CMD_ALLOC, 12'hEDC);
      // empty windows
      set_window(13'd4095, 13'd0);
      send_command(CMD_ALLOC, 12'h000);
      set_window(13'h0800, 13'h0800);
      send_command(CMD_ALLOC, 12'hFFF);
      // upper write data bit dropped on the first-index register
      set_window(13'h1005, 13'h1000);
      send_command(CMD_ALLOC, 12'h000);
      send_command(CMD_ALLOC, 12'h000);

      // random phases, each with its own window
      while (commands_sent < COMMAND_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               first_pick = 0;
               total_pick = BITMAP_BITS;
            end
            1: begin
               first_pick = $urandom_range(0, 4095);
               total_pick = $urandom_range(0, first_pick);
            end
            2: begin
               first_pick = $urandom_range(4040, 4095);
               total_pick = $urandom_range(4096, 8191);
            end
            3: begin
               first_pick = $urandom_range(0, 8191);
               total_pick = $urandom_range(0, 8191);
            end
            default: begin
               first_pick = $urandom_range(0, 4000);
               total_pick = first_pick + $urandom_range(1, 48);
            end
         endcase
         set_window(CSR_W'(first_pick), CSR_W'(total_pick));
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            unit = UNIT_W'($urandom());
            if (pick < 55)
               send_command(CMD_ALLOC, unit);
            else if (pick < 90 && free_hi > free_lo)
               send_command(CMD_FREE, UNIT_W'($urandom_range(free_lo, free_hi - 1)));
            else if (pick < 96)
               send_command(CMD_FREE, unit);
            else
               send_command(CMD_FREE, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("bitmap_first_free_allocator_tb: done, clean");
      else
         $display("bitmap_first_free_allocator_tb: done, errors");
      $finish;
   end

endmodule
